// ===== design/led_blink_sequencer_top_defines.svh =====
// ----------------------------------------------------------------------------
// led_blink_sequencer_top_defines
// assertion macros shared by the led blink sequencer
// ----------------------------------------------------------------------------
`ifndef LED_BLINK_SEQUENCER_TOP_DEFINES_SVH
`define LED_BLINK_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define LBS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbs_pkg
// types and constants of the led blink sequencer
// ----------------------------------------------------------------------------
package lbs_pkg;

    localparam int TIME_W  = 24;
    localparam int COUNT_W = 8;
    localparam int MODE_W  = 2;
    localparam int OUT_W   = 2;

    localparam logic [MODE_W-1:0]  MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0]  MODE_ON    = 2'd1;
    localparam logic [MODE_W-1:0]  MODE_BLINK = 2'd2;

    localparam logic               KIND_TICK  = 1'b0;
    localparam logic               KIND_START = 1'b1;

    localparam logic [COUNT_W-1:0] ENDLESS_COUNT = 8'hff;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  on_limit;
        logic [TIME_W-1:0]  off_limit;
        logic               phase;
    } t_led_cmd;

    typedef struct packed {
        logic pin;
        logic busy;
        logic pending;
    } t_led_status;

endpackage

// ===== design/led_blink_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// led_blink_sequencer_top
// blink pattern generator with a running and a pending slot per led
// ----------------------------------------------------------------------------
// Every input beat, tick or start command, yields one result beat with the
// pin levels, busy and pending masks after the update. A beat can be taken
// in every cycle unless stalled and moves through the stage and output
// registers: the on and off times are turned into ticks by a constant
// reciprocal multiply ahead of the stage register, and all leds are updated
// in parallel between the stage register and the output register. The input
// is stalled only while both registers hold a beat and the output is stalled.
module led_blink_sequencer_top #(
    parameter int LED_COUNT      = 2,
    parameter int TICK_PERIOD_MS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_kind,
    input  logic                        i_led_index,
    input  logic [lbs_pkg::MODE_W-1:0]  i_pattern_mode,
    input  logic [lbs_pkg::COUNT_W-1:0] i_repeat_count,
    input  logic [lbs_pkg::TIME_W-1:0]  i_on_time_ms,
    input  logic [lbs_pkg::TIME_W-1:0]  i_off_time_ms,
    input  logic                        i_start_level,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [lbs_pkg::OUT_W-1:0]   o_led_levels,
    output logic [lbs_pkg::OUT_W-1:0]   o_busy_mask,
    output logic [lbs_pkg::OUT_W-1:0]   o_pending_mask
);
    import lbs_pkg::*;

    `include "led_blink_sequencer_top_defines.svh"

    localparam int DIV_SHIFT = TIME_W + $clog2(TICK_PERIOD_MS);
    localparam int RECIP_W   = TIME_W + 1;
    localparam int PROD_W    = DIV_SHIFT + TIME_W;
    localparam longint unsigned DIV_RECIP_L =
        ((64'd1 << DIV_SHIFT) / TICK_PERIOD_MS) + 64'd1;
    localparam logic [RECIP_W-1:0] DIV_RECIP = DIV_RECIP_L[RECIP_W-1:0];

    logic                     r_s1_valid;
    logic                     r_s1_kind;
    logic                     r_s1_index;
    t_led_cmd                 r_s1_cmd;
    logic                     r_out_valid;
    logic [OUT_W-1:0]         r_levels;
    logic [OUT_W-1:0]         r_busy;
    logic [OUT_W-1:0]         r_pending;

    logic                     out_blocked;
    logic                     advance;
    logic                     in_take;
    logic [PROD_W-1:0]        on_prod;
    logic [PROD_W-1:0]        off_prod;
    t_led_cmd                 in_cmd;
    t_led_status              led_status [LED_COUNT];
    logic [OUT_W-1:0]         n_levels;
    logic [OUT_W-1:0]         n_busy;
    logic [OUT_W-1:0]         n_pending;

    assign out_blocked = r_out_valid && i_stall;
    assign advance     = r_s1_valid && !out_blocked;
    assign o_stall     = r_s1_valid && out_blocked;
    assign in_take     = i_valid && !o_stall;

    // ms to ticks, exact floor for every 24-bit value
    assign on_prod  = PROD_W'(i_on_time_ms)  * PROD_W'(DIV_RECIP);
    assign off_prod = PROD_W'(i_off_time_ms) * PROD_W'(DIV_RECIP);

    always_comb begin
        in_cmd.mode      = i_pattern_mode;
        in_cmd.count     = i_repeat_count - 1'b1;
        in_cmd.on_limit  = on_prod[DIV_SHIFT +: TIME_W];
        in_cmd.off_limit = off_prod[DIV_SHIFT +: TIME_W];
        in_cmd.phase     = i_start_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_s1_valid <= i_valid;
            end
            if (!out_blocked) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_kind  <= i_kind;
            r_s1_index <= i_led_index;
            r_s1_cmd   <= in_cmd;
        end
        if (advance) begin
            r_levels  <= n_levels;
            r_busy    <= n_busy;
            r_pending <= n_pending;
        end
    end

    for (genvar g = 0; g < LED_COUNT; g++) begin : g_led
        lbs_led u_led (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tick   (advance && r_s1_kind == KIND_TICK),
            .i_start  (advance && r_s1_kind == KIND_START && 32'(r_s1_index) == g),
            .i_cmd    (r_s1_cmd),
            .o_status (led_status[g])
        );
    end

    for (genvar b = 0; b < OUT_W; b++) begin : g_out
        if (b < LED_COUNT) begin : g_used
            assign n_levels[b]  = led_status[b].pin;
            assign n_busy[b]    = led_status[b].busy;
            assign n_pending[b] = led_status[b].pending;
        end else begin : g_unused
            assign n_levels[b]  = 1'b0;
            assign n_busy[b]    = 1'b0;
            assign n_pending[b] = 1'b0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_led_levels   = r_levels;
    assign o_busy_mask    = r_busy;
    assign o_pending_mask = r_pending;

    `LBS_ASSERT_SAME(a_pending_needs_busy, i_clk, i_rst_n, o_valid,
        (o_pending_mask & ~o_busy_mask) == '0, "pending led without a running pattern")

    `LBS_ASSERT_NEXT(a_stage_moves_to_out, i_clk, i_rst_n, advance,
        o_valid, "stage one beat lost on the way to the output register")

    `LBS_ASSERT_NEXT(a_held_stage_waits, i_clk, i_rst_n, o_stall,
        r_s1_valid && $stable(r_s1_cmd) && $stable(r_s1_kind),
        "stage one beat changed while the input was held off")

endmodule

// ===== design/lbs_led.sv =====
// ----------------------------------------------------------------------------
// lbs_led
// running and pending slot of one led, advanced by ticks and start beats
// ----------------------------------------------------------------------------
module lbs_led (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick,
    input  logic                 i_start,
    input  lbs_pkg::t_led_cmd    i_cmd,
    output lbs_pkg::t_led_status o_status
);
    import lbs_pkg::*;

    t_led_cmd          r_run,         n_run;
    t_led_cmd          r_wait,        n_wait;
    logic              r_run_active,  n_run_active;
    logic              r_wait_active, n_wait_active;
    logic              r_started,     n_started;
    logic              r_pin,         n_pin;
    logic [TIME_W-1:0] r_ticks,       n_ticks;

    always_comb begin
        n_run         = r_run;
        n_wait        = r_wait;
        n_run_active  = r_run_active;
        n_wait_active = r_wait_active;
        n_started     = r_started;
        n_pin         = r_pin;
        n_ticks       = r_ticks;
        if (i_tick && r_run_active) begin
            if (r_run.mode == MODE_OFF || r_run.mode == MODE_ON) begin
                n_run_active = 1'b0;
                n_started    = 1'b0;
                n_run.phase  = r_run.mode[0];
                n_pin        = r_run.mode[0];
            end else if (!r_started) begin
                n_started = 1'b1;
                n_ticks   = '0;
                n_pin     = r_run.phase;
            end else if (r_run.phase) begin
                if (r_ticks >= r_run.on_limit) begin
                    n_run.phase = 1'b0;
                    n_ticks     = '0;
                    n_pin       = 1'b0;
                end else begin
                    n_ticks = r_ticks + 1'b1;
                end
            end else begin
                if (r_ticks >= r_run.off_limit) begin
                    if (r_run.count != '0) begin
                        if (r_run.count != ENDLESS_COUNT) begin
                            n_run.count = r_run.count - 1'b1;
                        end
                        n_run.phase = 1'b1;
                        n_ticks     = '0;
                        n_pin       = 1'b1;
                    end else begin
                        n_run_active = 1'b0;
                    end
                end else begin
                    n_ticks = r_ticks + 1'b1;
                end
            end
            // pick up the queued pattern once the run is over
            if (!n_run_active && r_wait_active) begin
                n_run_active  = 1'b1;
                n_wait_active = 1'b0;
                n_run         = r_wait;
                n_started     = 1'b0;
            end
        end else if (i_start) begin
            if (r_run_active) begin
                n_wait_active = 1'b1;
                n_wait        = i_cmd;
            end else begin
                n_wait_active = 1'b0;
                n_run_active  = 1'b1;
                n_run         = i_cmd;
                n_started     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_active  <= 1'b0;
            r_wait_active <= 1'b0;
            r_started     <= 1'b0;
            r_pin         <= 1'b0;
        end else begin
            r_run_active  <= n_run_active;
            r_wait_active <= n_wait_active;
            r_started     <= n_started;
            r_pin         <= n_pin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run   <= n_run;
        r_wait  <= n_wait;
        r_ticks <= n_ticks;
    end

    assign o_status = '{pin: n_pin, busy: n_run_active, pending: n_wait_active};

endmodule

// ===== test/led_blink_sequencer_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_blink_sequencer_top_test
// self-checking bench for the two-led blink pattern sequencer
// ----------------------------------------------------------------------------
// A directed table walks both leds through steady modes, blink with zero
// times, pending replacement and full-scale fields; then random ticks and
// start commands, mostly short blink patterns so runs end and queued
// commands get loaded, with full-range beats at the end. A behavioral model
// of the per-led running and pending slots predicts each result beat that
// no table row gives, and all are compared field by field. Both sides idle
// and stall at random; one long receiver hold-off backs up the pipeline.
// ----------------------------------------------------------------------------
module led_blink_sequencer_top_test;

    import lbs_pkg::*;

    localparam int LEDS          = 2;
    localparam int TICK_MS       = 10;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_BEATS  = 1480;
    localparam int WILD_BEATS    = 120;
    localparam int HOLD_CYCLES   = 300;
    localparam int TIMEOUT_NS    = 5_000_000;

    localparam logic [MODE_W-1:0] MODE_BLINK_ALT = 2'd3;

    typedef struct packed {
        logic               kind;
        logic               led;
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  on_ms;
        logic [TIME_W-1:0]  off_ms;
        logic               level;
    } t_beat;

    typedef struct packed {
        logic [OUT_W-1:0] levels;
        logic [OUT_W-1:0] busy;
        logic [OUT_W-1:0] pending;
    } t_result;

    typedef struct packed {
        t_beat   beat;
        logic    typed;
        t_result want;
    } t_stim_row;

    typedef struct packed {
        logic     active;
        t_led_cmd cmd;
    } t_slot;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_kind;
    logic                 i_led_index;
    logic [MODE_W-1:0]    i_pattern_mode;
    logic [COUNT_W-1:0]   i_repeat_count;
    logic [TIME_W-1:0]    i_on_time_ms;
    logic [TIME_W-1:0]    i_off_time_ms;
    logic                 i_start_level;
    logic                 o_valid;
    logic                 i_stall;
    logic [OUT_W-1:0]     o_led_levels;
    logic [OUT_W-1:0]     o_busy_mask;
    logic [OUT_W-1:0]     o_pending_mask;

    // led model state
    t_slot               run_slot [0:LEDS-1];
    t_slot               queued_slot [0:LEDS-1];
    logic                run_started [0:LEDS-1];
    logic [TIME_W-1:0]   phase_ticks [0:LEDS-1];
    logic                pin_level [0:LEDS-1];

    t_result expected_status [$];
    int      mismatch_count = 0;
    int      result_count = 0;
    int      tick_count = 0;
    int      start_count = 0;
    int      queued_count = 0;
    int      load_count = 0;
    bit      hold_req = 0;

    t_stim_row directed_rows [0:DIRECTED_ROWS-1] = '{
        '{'{KIND_TICK, 1'b0, MODE_OFF, 8'd0, 24'd0, 24'd0, 1'b0},
          1'b1, '{2'b00, 2'b00, 2'b00}},
        '{'{KIND_START, 1'b0, MODE_ON, 8'd255, 24'hffffff, 24'hffffff, 1'b0},
          1'b1, '{2'b00, 2'b01, 2'b00}},
        '{'{KIND_START, 1'b0, MODE_BLINK, 8'd0, 24'hffffff, 24'hffffff, 1'b1},
          1'b1, '{2'b00, 2'b01, 2'b01}},
        '{'{KIND_START, 1'b0, MODE_BLINK_ALT, 8'd1, 24'd0, 24'd0, 1'b1},
          1'b1, '{2'b00, 2'b01, 2'b01}},
        '{'{KIND_START, 1'b1, MODE_OFF, 8'd0, 24'd0, 24'd0, 1'b0},
          1'b1, '{2'b00, 2'b11, 2'b01}},
        '{'{KIND_TICK, 1'b0, MODE_OFF, 8'd0, 24'd0, 24'd0, 1'b0},
          1'b1, '{2'b01, 2'b01, 2'b00}},
        '{'{KIND_TICK, 1'b1, MODE_ON, 8'd255, 24'hffffff, 24'hffffff, 1'b1},
          1'b1, '{2'b01, 2'b01, 2'b00}},
        '{'{KIND_TICK, 1'b0, MODE_OFF, 8'd0, 24'd0, 24'd0, 1'b0},
          1'b1, '{2'b00, 2'b01, 2'b00}},
        '{'{KIND_TICK, 1'b0, MODE_OFF, 8'd0, 24'd0, 24'd0, 1'b0},
          1'b1, '{2'b00, 2'b00, 2'b00}},
        '{'{KIND_START, 1'b1, MODE_BLINK, 8'd2, 24'd19, 24'd9, 1'b0},
          1'b0, '0},
        '{'{KIND_START, 1'b1, MODE_BLINK, 8'd0, 24'd0, 24'hffffff, 1'b1},
          1'b0, '0},
        '{'{KIND_START, 1'b1, MODE_BLINK_ALT, 8'd255, 24'hffffff, 24'd0, 1'b0},
          1'b0, '0},
        '{'{KIND_START, 1'b1, MODE_OFF, 8'd7, 24'd0, 24'd0, 1'b1},
          1'b0, '0},
        '{'{KIND_START, 1'b0, MODE_ON, 8'd0, 24'd5, 24'd5, 1'b1},
          1'b0, '0},
        '{'{KIND_TICK, 1'b0, MODE_OFF, 8'd0, 24'd0, 24'd0, 1'b0}, 1'b0, '0},
        '{'{KIND_TICK, 1'b0, MODE_OFF, 8'd0, 24'd0, 24'd0, 1'b0}, 1'b0, '0},
        '{'{KIND_TICK, 1'b0, MODE_OFF, 8'd0, 24'd0, 24'd0, 1'b0}, 1'b0, '0},
        '{'{KIND_TICK, 1'b0, MODE_OFF, 8'd0, 24'd0, 24'd0, 1'b0}, 1'b0, '0},
        '{'{KIND_TICK, 1'b0, MODE_OFF, 8'd0, 24'd0, 24'd0, 1'b0}, 1'b0, '0},
        '{'{KIND_TICK, 1'b0, MODE_OFF, 8'd0, 24'd0, 24'd0, 1'b0}, 1'b0, '0},
        '{'{KIND_TICK, 1'b0, MODE_OFF, 8'd0, 24'd0, 24'd0, 1'b0}, 1'b0, '0},
        '{'{KIND_TICK, 1'b0, MODE_OFF, 8'd0, 24'd0, 24'd0, 1'b0}, 1'b0, '0},
        '{'{KIND_START, 1'b0, MODE_BLINK, 8'd1, 24'd9, 24'd10, 1'b0},
          1'b0, '0},
        '{'{KIND_TICK, 1'b0, MODE_OFF, 8'd0, 24'd0, 24'd0, 1'b0}, 1'b0, '0},
        '{'{KIND_TICK, 1'b0, MODE_OFF, 8'd0, 24'd0, 24'd0, 1'b0}, 1'b0, '0}
    };

    led_blink_sequencer_top #(
        .LED_COUNT      (LEDS),
        .TICK_PERIOD_MS (TICK_MS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_led_index    (i_led_index),
        .i_pattern_mode (i_pattern_mode),
        .i_repeat_count (i_repeat_count),
        .i_on_time_ms   (i_on_time_ms),
        .i_off_time_ms  (i_off_time_ms),
        .i_start_level  (i_start_level),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_led_levels   (o_led_levels),
        .o_busy_mask    (o_busy_mask),
        .o_pending_mask (o_pending_mask)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // one tick of a running led, then load the queued command if the run ended
    function automatic void tick_led(int k);
        if (run_slot[k].cmd.mode == MODE_OFF || run_slot[k].cmd.mode == MODE_ON) begin
            run_slot[k].active = 1'b0;
            run_started[k] = 1'b0;
            run_slot[k].cmd.phase = run_slot[k].cmd.mode[0];
            pin_level[k] = run_slot[k].cmd.mode[0];
        end else if (!run_started[k]) begin
            run_started[k] = 1'b1;
            phase_ticks[k] = '0;
            pin_level[k] = run_slot[k].cmd.phase;
        end else if (run_slot[k].cmd.phase) begin
            if (phase_ticks[k] >= run_slot[k].cmd.on_limit) begin
                run_slot[k].cmd.phase = 1'b0;
                phase_ticks[k] = '0;
                pin_level[k] = 1'b0;
            end else begin
                phase_ticks[k] = phase_ticks[k] + 1'b1;
            end
        end else begin
            if (phase_ticks[k] >= run_slot[k].cmd.off_limit) begin
                if (run_slot[k].cmd.count != '0) begin
                    if (run_slot[k].cmd.count != ENDLESS_COUNT)
                        run_slot[k].cmd.count = run_slot[k].cmd.count - 1'b1;
                    run_slot[k].cmd.phase = 1'b1;
                    phase_ticks[k] = '0;
                    pin_level[k] = 1'b1;
                end else begin
                    run_slot[k].active = 1'b0;
                end
            end else begin
                phase_ticks[k] = phase_ticks[k] + 1'b1;
            end
        end
        if (!run_slot[k].active && queued_slot[k].active) begin
            run_slot[k] = queued_slot[k];
            queued_slot[k].active = 1'b0;
            run_started[k] = 1'b0;
            load_count++;
        end
    endfunction

    function automatic t_result next_status(t_beat b);
        t_result r;
        t_slot   cmd;
        if (b.kind == KIND_START) begin
            start_count++;
            cmd.active = 1'b1;
            cmd.cmd.mode = b.mode;
            cmd.cmd.count = b.count - 1'b1;
            cmd.cmd.on_limit = TIME_W'(b.on_ms / TICK_MS);
            cmd.cmd.off_limit = TIME_W'(b.off_ms / TICK_MS);
            cmd.cmd.phase = b.level;
            if (run_slot[b.led].active) begin
                queued_slot[b.led] = cmd;
                queued_count++;
            end else begin
                queued_slot[b.led].active = 1'b0;
                run_slot[b.led] = cmd;
                run_started[b.led] = 1'b0;
            end
        end else begin
            tick_count++;
            for (int k = 0; k < LEDS; k++)
                if (run_slot[k].active)
                    tick_led(k);
        end
        for (int k = 0; k < LEDS; k++) begin
            r.levels[k] = pin_level[k];
            r.busy[k] = run_slot[k].active;
            r.pending[k] = queued_slot[k].active;
        end
        return r;
    endfunction

    // short patterns keep runs ending; wild beats use the full field ranges
    function automatic t_beat random_beat(bit wild);
        t_beat b;
        int    pick;
        b.led = 1'($urandom_range(0, 1));
        b.level = 1'($urandom_range(0, 1));
        if (wild) begin
            b.kind = 1'($urandom_range(0, 1));
            b.mode = MODE_W'($urandom_range(0, 3));
            b.count = COUNT_W'($urandom);
            b.on_ms = TIME_W'($urandom);
            b.off_ms = TIME_W'($urandom);
        end else begin
            b.kind = ($urandom_range(0, 9) < 6) ? KIND_TICK : KIND_START;
            pick = $urandom_range(0, 9);
            b.mode = (pick == 0) ? MODE_OFF : (pick == 1) ? MODE_ON :
                     (pick == 2) ? MODE_BLINK_ALT : MODE_BLINK;
            b.count = COUNT_W'($urandom_range(1, 4));
            b.on_ms = TIME_W'($urandom_range(0, 49));
            b.off_ms = TIME_W'($urandom_range(0, 49));
        end
        return b;
    endfunction

    bit send_burst = 0;

    task automatic offer_beat(t_beat b, bit typed, t_result want);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind = b.kind;
        i_led_index = b.led;
        i_pattern_mode = b.mode;
        i_repeat_count = b.count;
        i_on_time_ms = b.on_ms;
        i_off_time_ms = b.off_ms;
        i_start_level = b.level;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_status.push_back(typed ? want : next_status(b));
        if (typed)
            void'(next_status(b));
        @(negedge i_clk);
    endtask

    initial begin : drive_inputs
        t_beat b;
        t_beat w;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = KIND_TICK;
        i_led_index = 1'b0;
        i_pattern_mode = MODE_OFF;
        i_repeat_count = '0;
        i_on_time_ms = '0;
        i_off_time_ms = '0;
        i_start_level = 1'b0;
        for (int k = 0; k < LEDS; k++) begin
            run_slot[k] = '0;
            queued_slot[k] = '0;
            run_started[k] = 1'b0;
            phase_ticks[k] = '0;
            pin_level[k] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int n = 0; n < DIRECTED_ROWS; n++)
            offer_beat(directed_rows[n].beat, directed_rows[n].typed, directed_rows[n].want);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 64 == 0)
                send_burst = ($urandom_range(0, 2) == 0);
            if (n == 400)
                hold_req = 1'b1;
            b = random_beat(n >= RANDOM_BEATS - WILD_BEATS);
            // full-scale command parked in the pending slot, then replaced
            if (b.kind == KIND_START && run_slot[b.led].active &&
                $urandom_range(0, 7) == 0) begin
                w = random_beat(1'b1);
                w.kind = KIND_START;
                w.led = b.led;
                offer_beat(w, 1'b0, '0);
                b.kind = KIND_START;
            end
            offer_beat(b, 1'b0, '0);
        end
        i_valid = 1'b0;

        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Checked %0d result beats from %0d ticks and %0d start commands",
                 result_count, tick_count, start_count);
        $display("%0d commands queued behind a running pattern, %0d loaded on a tick",
                 queued_count, load_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin : drain_outputs
        int  n;
        int  taken;
        bit  burst;
        bit  held;
        i_stall = 1'b0;
        taken = 0;
        burst = 1'b0;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (taken % 64 == 0)
                burst = ($urandom_range(0, 2) == 0);
            if (hold_req && !held) begin
                i_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                held = 1'b1;
            end
            n = burst ? 0 : $urandom_range(0, 9);
            if (n > 0) begin
                i_stall = 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_stall = 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            taken++;
        end
    end

    always @(posedge i_clk) begin : check_result
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            if (expected_status.size() == 0) begin
                $error("result beat with no expectation: levels %b busy %b pending %b",
                       o_led_levels, o_busy_mask, o_pending_mask);
                mismatch_count++;
            end else begin
                want = expected_status.pop_front();
                if (o_led_levels !== want.levels) begin
                    $error("led_levels expected %b actual %b", want.levels, o_led_levels);
                    mismatch_count++;
                end
                if (o_busy_mask !== want.busy) begin
                    $error("busy_mask expected %b actual %b", want.busy, o_busy_mask);
                    mismatch_count++;
                end
                if (o_pending_mask !== want.pending) begin
                    $error("pending_mask expected %b actual %b", want.pending, o_pending_mask);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", expected_status.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== led_blink_sequencer_top.f =====
+incdir+design
design/lbs_pkg.sv
design/lbs_led.sv
design/led_blink_sequencer_top.sv
test/led_blink_sequencer_top_test.sv
